/* src/cmcd_pkg.sv */
// Shared types and constants for the camera module counter decoder.
package cmcd_pkg;

    // Present-module counter saturates at this value; the index is its low bits.
    localparam int unsigned COUNT_W     = 10;
    localparam int unsigned INDEX_W     = 9;
    localparam logic [COUNT_W-1:0] MAX_MODULES = 10'd512;

    // Trigger layout: four bytes, seven channels, one nibble per channel.
    localparam int unsigned NUM_CH      = 7;
    localparam int unsigned NUM_BYTES   = 4;

    // Reset value of the suspect threshold and the sequence scale factor.
    localparam logic [31:0] DEFAULT_THRESHOLD = 32'd124987500;
    localparam logic [29:0] SEQ_SCALE         = 30'd1000000000;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 288;
    localparam int unsigned M_TUSER_W = 2;

    // One module record as received.
    typedef struct packed {
        logic              module_present;
        logic [15:0]       pps_count;
        logic [15:0]       pps_event_count;
        logic [31:0]       coarse_time;
        logic signed [7:0] fine_event_time;
        logic signed [7:0] fine_bunch_time;
        logic [31:0]       trig_bytes;
        logic              last_module;
    } cmcd_item_t;

    // Per-module decode, zero for an absent module.
    typedef struct packed {
        logic [27:0] trigger_image;
        logic [6:0]  hit_mask;
        logic [31:0] event_time;
        logic [16:0] time_sequence;
        logic        clock_suspect;
    } cmcd_decode_t;

    // Complete result record.
    typedef struct packed {
        logic               module_valid;
        logic [INDEX_W-1:0] present_index;
        cmcd_decode_t       dec;
        logic               sums_valid;
        logic [63:0]        time_sum;
        logic [63:0]        sequence_sum;
        logic [63:0]        combined_time;
        logic               any_suspect;
    } cmcd_result_t;

endpackage

/* src/cmcd_decode.sv */
// Per-module decode: trigger image, hit mask, event time and suspect check.
module cmcd_decode
    import cmcd_pkg::*;
(
    input  cmcd_item_t   item,
    input  logic [31:0]  threshold,
    output cmcd_decode_t dec
);

    logic [27:0] image;
    logic [6:0]  mask;
    logic [31:0] time_raw;
    logic        suspect;
    logic [16:0] seq;

    // Channel k nibble gathers bit k of each trigger byte, byte 0 in the lowest bit.
    always_comb
    begin
        image = '0;
        mask  = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            for (int b = 0; b < NUM_BYTES; b++)
            begin
                image[4*ch + b] = item.trig_bytes[8*b + ch];
            end
            mask[ch] = |image[4*ch +: 4];
        end
    end

    // Bunch event time in fine units, wrapping at 32 bits.
    assign time_raw = {item.coarse_time[28:0], 3'b000}
                    + {{24{item.fine_event_time[7]}}, item.fine_event_time}
                    - {{24{item.fine_bunch_time[7]}}, item.fine_bunch_time};

    // Clock is suspect on the first event of a bunch with a late coarse time.
    assign suspect = (item.pps_event_count == 16'd1) && (item.coarse_time > threshold);
    assign seq     = {1'b0, item.pps_count} - {16'd0, suspect};

    // Absent modules give all-zero fields.
    always_comb
    begin
        if (item.module_present)
        begin
            dec.trigger_image = image;
            dec.hit_mask      = mask;
            dec.event_time    = time_raw;
            dec.time_sequence = seq;
            dec.clock_suspect = suspect;
        end
        else
        begin
            dec = '0;
        end
    end

endmodule

/* src/camera_module_counter_decoder.sv */
// Top level of the camera module counter decoder: stream pipeline and event sums.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata record, s_tuser presence, s_tlast
//  m_*       out        m_tvalid/m_tready  m_tdata result, m_tuser valid flags
//  cfg_*     in         cfg_valid/ready    cfg_data suspect threshold
//
// One record is taken every cycle while s_tready is high. The depth is set by the
// input register, the decode and sum stage, the 32-bit partial products of the 1e9
// scaling and the final 64-bit add.
// Reset clears the valid bits, the event sums and restores the default threshold.
// A stall on m_tready fills empty stages first; s_tready falls only when all
// four stages hold a record.
module camera_module_counter_decoder
    import cmcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata, lowest bit up: pps_count[15:0], pps_event_count[15:0],
    // coarse_time[31:0], fine_event_time[7:0], fine_bunch_time[7:0],
    // trig_bytes[31:0]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: module_present
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata, lowest bit up: present_index[8:0], trigger_image[27:0],
    // hit_mask[6:0], event_time[31:0], time_sequence[16:0], clock_suspect,
    // time_sum[63:0], sequence_sum[63:0], combined_time[63:0], any_suspect,
    // one zero pad bit
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser, lowest bit up: module_valid, sums_valid
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    // Pipeline valid bits and stage enables.
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic en_a, en_b, en_c, en_d;

    // Stage registers.
    cmcd_item_t   a_item_reg;
    cmcd_result_t b_res_reg, b_res_next;
    cmcd_result_t c_res_reg;
    logic [61:0]  c_plo_reg;
    logic [31:0]  c_phi_reg;
    cmcd_result_t d_res_reg, d_res_next;

    // Event state.
    logic [31:0]        threshold_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [63:0]        tsum_reg, tsum_next;
    logic [63:0]        ssum_reg, ssum_next;
    logic               susp_reg, susp_next;
    logic               allp_reg, allp_next;

    cmcd_decode_t dec;
    logic [63:0]  tsum_acc, ssum_acc;
    logic         susp_acc, allp_acc;
    logic [63:0]  combined;

    // A stage loads when it is empty or its contents move on.
    assign en_d     = !d_valid_reg || m_tready;
    assign en_c     = !c_valid_reg || en_d;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign s_tready = en_a;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= DEFAULT_THRESHOLD;
        end
        else if (cfg_valid)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (en_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Input register: unpack the transaction into the record.
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_item_reg.module_present  <= s_tuser[0];
            a_item_reg.pps_count       <= s_tdata[15:0];
            a_item_reg.pps_event_count <= s_tdata[31:16];
            a_item_reg.coarse_time     <= s_tdata[63:32];
            a_item_reg.fine_event_time <= s_tdata[71:64];
            a_item_reg.fine_bunch_time <= s_tdata[79:72];
            a_item_reg.trig_bytes      <= s_tdata[111:80];
            a_item_reg.last_module     <= s_tlast;
        end
    end

    cmcd_decode u_decode (
        .item      (a_item_reg),
        .threshold (threshold_reg),
        .dec       (dec)
    );

    // Fold this module into the event sums and form the stage-B record.
    always_comb
    begin
        tsum_acc = tsum_reg;
        ssum_acc = ssum_reg;
        susp_acc = susp_reg;
        allp_acc = allp_reg && a_item_reg.module_present;
        count_next = count_reg;
        if (a_item_reg.module_present)
        begin
            tsum_acc = tsum_reg + {{32{dec.event_time[31]}}, dec.event_time};
            ssum_acc = ssum_reg + {{47{dec.time_sequence[16]}}, dec.time_sequence};
            susp_acc = susp_reg || dec.clock_suspect;
            if (count_reg < MAX_MODULES)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        b_res_next               = '0;
        b_res_next.module_valid  = a_item_reg.module_present;
        b_res_next.present_index = a_item_reg.module_present ? count_reg[INDEX_W-1:0] : '0;
        b_res_next.dec           = dec;

        tsum_next = tsum_acc;
        ssum_next = ssum_acc;
        susp_next = susp_acc;
        allp_next = allp_acc;
        if (a_item_reg.last_module)
        begin
            if (allp_acc)
            begin
                b_res_next.sums_valid   = 1'b1;
                b_res_next.time_sum     = tsum_acc;
                b_res_next.sequence_sum = ssum_acc;
                b_res_next.any_suspect  = susp_acc;
            end
            count_next = '0;
            tsum_next  = '0;
            ssum_next  = '0;
            susp_next  = 1'b0;
            allp_next  = 1'b1;
        end
    end

    // Event state advances once per record entering stage B.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tsum_reg  <= '0;
            ssum_reg  <= '0;
            susp_reg  <= 1'b0;
            allp_reg  <= 1'b1;
        end
        else if (en_b && a_valid_reg)
        begin
            count_reg <= count_next;
            tsum_reg  <= tsum_next;
            ssum_reg  <= ssum_next;
            susp_reg  <= susp_next;
            allp_reg  <= allp_next;
        end
    end

    // Combined time, wrapping at 64 bits; zero when no sums are emitted.
    assign combined = {2'b00, c_plo_reg} + {c_phi_reg, 32'd0} + c_res_reg.time_sum;

    // Stage-D record: stage-C contents with the combined time filled in.
    always_comb
    begin
        d_res_next               = c_res_reg;
        d_res_next.combined_time = combined;
    end

    // Payload registers of stages B to D; the scaling is split into two partial products.
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_res_reg <= b_res_next;
        end
        if (en_c)
        begin
            c_res_reg <= b_res_reg;
            c_plo_reg <= 62'(b_res_reg.sequence_sum[31:0]) * 62'(SEQ_SCALE);
            c_phi_reg <= b_res_reg.sequence_sum[63:32] * 32'(SEQ_SCALE);
        end
        if (en_d)
        begin
            d_res_reg <= d_res_next;
        end
    end

    // Output packing.
    assign m_tvalid = d_valid_reg;
    assign m_tuser  = {d_res_reg.sums_valid, d_res_reg.module_valid};
    assign m_tdata  = {1'b0,
                       d_res_reg.any_suspect,
                       d_res_reg.combined_time,
                       d_res_reg.sequence_sum,
                       d_res_reg.time_sum,
                       d_res_reg.dec.clock_suspect,
                       d_res_reg.dec.time_sequence,
                       d_res_reg.dec.event_time,
                       d_res_reg.dec.hit_mask,
                       d_res_reg.dec.trigger_image,
                       d_res_reg.present_index};

    // The present-module counter never passes its saturation value.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= MAX_MODULES)
        else $error("present-module count above saturation");

    // After the last module of an event enters stage B, the event state is clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        en_b && a_valid_reg && a_item_reg.last_module
        |=> count_reg == '0 && tsum_reg == '0 && ssum_reg == '0 && !susp_reg && allp_reg)
        else $error("event state not cleared after last module");

    // Input back-pressure only when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> a_valid_reg && b_valid_reg && c_valid_reg && d_valid_reg)
        else $error("input stalled with an empty stage");

    // A result without emitted sums carries zero sums and zero combined time.
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !d_res_reg.sums_valid
        |-> d_res_reg.time_sum == '0 && d_res_reg.sequence_sum == '0
            && d_res_reg.combined_time == '0 && !d_res_reg.any_suspect)
        else $error("sums present without sums_valid");

endmodule
